// ----- rtl/esc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg: shared definitions for the epoch-seconds to calendar converter
// Constant divisors, reciprocals, result layout and calendar helpers.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Pipeline depth, input register to output register
    localparam int unsigned STAGES = 10;

    // Seconds per day split as 128 * 675: shift by 7, then divide by 675
    localparam logic [9:0]  DAY_DIV       = 10'd675;
    localparam logic [24:0] DAY_RECIP     = 25'd25451658;   // floor(2^34 / 675)
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [15:0] YEAR_RECIP    = 16'd45964;      // floor(2^24 / 365)
    localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;
    localparam logic [16:0] WEEK_RECIP    = 17'd74898;      // floor(2^19 / 7)
    localparam logic [16:0] EPOCH_WDAY    = 17'd4;          // first day was a Thursday
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [13:0] HOUR_RECIP    = 14'd9320;       // floor(2^21 / 225)
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [10:0] MIN_RECIP     = 11'd1092;       // floor(2^14 / 15)

    // Year bookkeeping, years counted from 1970 (offset) or from 1900
    localparam logic [7:0]  EPOCH_YEAR_1900 = 8'd70;
    localparam logic [11:0] EPOCH_YEAR_PREV = 12'd1969;
    localparam logic [9:0]  LEAPS_AT_EPOCH  = 10'd492;      // floor(1969 / 4), four-year rule only
    localparam logic [7:0]  OFFSET_Y2100    = 8'd131;       // 1969 + 131 = 2100
    localparam logic [7:0]  YEAR_2100_1900  = 8'd200;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [8:0] day_of_year;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_cal;

    // Gregorian rule over 1969..2106: 2100 is the only century year that is not leap
    function automatic logic f_is_leap(input logic [7:0] year_1900);
        f_is_leap = (year_1900[1:0] == 2'b00) && (year_1900 != YEAR_2100_1900);
    endfunction

    // Day of year (zero-based) on which a month starts
    function automatic logic [8:0] f_month_start(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        base = 9'd0;
        case (month)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (month >= 4'd2)) begin
            base = base + 9'd1;
        end
        f_month_start = base;
    endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970-01-01 to Gregorian calendar
// Ten-stage pipeline built from reciprocal multiplies and compare-subtract
// corrections; one request per cycle unless m_axis stalls, no divider units.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (tdata, lowest bit first)
//  -------  ---------  -----------------------------------------------------
//  s_axis   in         epoch_seconds[31:0]
//  m_axis   out        second[5:0] minute[11:6] hour[16:12] day_of_month[21:17]
//                      month_index[25:22] years_since_1900[33:26]
//                      weekday[36:34] day_of_year[45:37] zero pad[47:46]
//
//  Stage 1 loads at the accept edge; the result then moves through S2 to S10
//  and is presented from the S10 output register.
//  Throughput is one request per cycle while m_axis does not stall, through
//  10 register stages.
//  Reset (i_rst_n low, synchronous) clears the stage valid bits only.
//  A stall on m_axis holds the full stages; empty stages still fill, so
//  s_axis_tready drops only when every stage holds a request.
//
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // epoch_seconds[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // see table above, bit 0 = second[0]
);

    // Stage advance: a stage loads when it is empty or its successor moves
    logic [esc_pkg::STAGES+1:1] n_adv;
    logic [esc_pkg::STAGES:1]   r_vld;

    always_comb begin
        n_adv[esc_pkg::STAGES+1] = m_axis_tready;
        for (int k = esc_pkg::STAGES; k >= 1; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= esc_pkg::STAGES; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = n_adv[1];
    assign m_axis_tvalid = r_vld[esc_pkg::STAGES];

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    // S1: day quotient estimate
    logic [15:0] r_s1_q;
    logic [24:0] r_s1_x;
    logic [6:0]  r_s1_lo;
    // S2: day remainder estimate
    logic [15:0] r_s2_q;
    logic [10:0] r_s2_r;
    logic [6:0]  r_s2_lo;
    // S3: exact days and seconds of day
    logic [15:0] r_s3_days;
    logic [16:0] r_s3_rem;
    // S4: year, week and hour quotient estimates
    logic [15:0] r_s4_days;
    logic [16:0] r_s4_wx;
    logic [16:0] r_s4_rem;
    logic [7:0]  r_s4_yest;
    logic [12:0] r_s4_west;
    logic [4:0]  r_s4_hest;
    // S5: remainders of the estimates
    logic [7:0]  r_s5_yest;
    logic [9:0]  r_s5_yr;
    logic [3:0]  r_s5_wr;
    logic [4:0]  r_s5_hest;
    logic [12:0] r_s5_hr;
    // S6: exact year offset, weekday, hour
    logic [7:0]  r_s6_q;
    logic [8:0]  r_s6_yrem;
    logic [2:0]  r_s6_wday;
    logic [4:0]  r_s6_hour;
    logic [11:0] r_s6_rem2;
    // S7: leap-adjusted day of year, minute estimate
    logic [9:0]  r_s7_d0;
    logic [7:0]  r_s7_q;
    logic        r_s7_leap_cur;
    logic        r_s7_leap_prev;
    logic [2:0]  r_s7_wday;
    logic [4:0]  r_s7_hour;
    logic [11:0] r_s7_rem2;
    logic [5:0]  r_s7_mest;
    // S8: final day of year and year
    logic [8:0]  r_s8_d;
    logic [7:0]  r_s8_year;
    logic        r_s8_leap;
    logic [2:0]  r_s8_wday;
    logic [4:0]  r_s8_hour;
    logic [5:0]  r_s8_mest;
    logic [6:0]  r_s8_mr;
    // S9: month, minute, second
    logic [8:0]  r_s9_d;
    logic [7:0]  r_s9_year;
    logic        r_s9_leap;
    logic [2:0]  r_s9_wday;
    logic [4:0]  r_s9_hour;
    logic [3:0]  r_s9_month;
    logic [5:0]  r_s9_min;
    logic [5:0]  r_s9_sec;
    // S10: output register
    esc_pkg::t_cal r_s10_out;

    // ------------------------------------------------------------------
    // Next-value logic
    // ------------------------------------------------------------------
    logic [49:0] n_s1_prod;
    logic [25:0] n_s2_qm;
    logic [25:0] n_s2_diff;
    logic        n_s3_ge;
    logic [10:0] n_s3_r;
    logic [16:0] n_s4_wx;
    logic [31:0] n_s4_yprod;
    logic [33:0] n_s4_wprod;
    logic [26:0] n_s4_hprod;
    logic [16:0] n_s5_ym;
    logic [16:0] n_s5_yr;
    logic [16:0] n_s5_wm;
    logic [16:0] n_s5_wr;
    logic [16:0] n_s5_hm;
    logic [16:0] n_s5_hr;
    logic        n_s6_yge;
    logic        n_s6_wge;
    logic        n_s6_hge;
    logic [9:0]  n_s6_yrem;
    logic [3:0]  n_s6_wday;
    logic [12:0] n_s6_rem2;
    logic [11:0] n_s7_yr;
    logic [9:0]  n_s7_leaps;
    logic [9:0]  n_s7_d0;
    logic [20:0] n_s7_mprod;
    logic        n_s8_neg;
    logic [9:0]  n_s8_d;
    logic [11:0] n_s8_mm;
    logic [11:0] n_s8_mr;
    logic        n_s9_mge;
    logic [6:0]  n_s9_sec;
    logic [3:0]  n_s9_month;
    logic [8:0]  n_s10_dom;
    esc_pkg::t_cal n_s10_out;

    always_comb begin
        // Days = (t >> 7) / 675 through a reciprocal; estimate may be one low
        n_s1_prod = 50'(s_axis_tdata[31:7]) * 50'(esc_pkg::DAY_RECIP);

        n_s2_qm   = 26'(r_s1_q) * 26'(esc_pkg::DAY_DIV);
        n_s2_diff = 26'(r_s1_x) - n_s2_qm;

        // Correct the day estimate; rebuild seconds of day from both halves
        n_s3_ge = (r_s2_r >= 11'(esc_pkg::DAY_DIV));
        n_s3_r  = n_s3_ge ? (r_s2_r - 11'(esc_pkg::DAY_DIV)) : r_s2_r;

        // Three independent reciprocal estimates: years, weeks, hours
        n_s4_wx    = 17'(r_s3_days) + esc_pkg::EPOCH_WDAY;
        n_s4_yprod = 32'(r_s3_days) * 32'(esc_pkg::YEAR_RECIP);
        n_s4_wprod = 34'(n_s4_wx) * 34'(esc_pkg::WEEK_RECIP);
        n_s4_hprod = 27'(r_s3_rem[16:4]) * 27'(esc_pkg::HOUR_RECIP);

        n_s5_ym = 17'(r_s4_yest) * 17'(esc_pkg::DAYS_PER_YEAR);
        n_s5_yr = 17'(r_s4_days) - n_s5_ym;
        n_s5_wm = 17'(r_s4_west) * 17'(esc_pkg::DAYS_PER_WEEK);
        n_s5_wr = r_s4_wx - n_s5_wm;
        n_s5_hm = 17'(r_s4_hest) * 17'(esc_pkg::SECS_PER_HOUR);
        n_s5_hr = r_s4_rem - n_s5_hm;

        // Fold each estimate that came out one low
        n_s6_yge  = (r_s5_yr >= 10'(esc_pkg::DAYS_PER_YEAR));
        n_s6_yrem = n_s6_yge ? (r_s5_yr - 10'(esc_pkg::DAYS_PER_YEAR)) : r_s5_yr;
        n_s6_wge  = (r_s5_wr >= esc_pkg::DAYS_PER_WEEK);
        n_s6_wday = n_s6_wge ? (r_s5_wr - esc_pkg::DAYS_PER_WEEK) : r_s5_wr;
        n_s6_hge  = (r_s5_hr >= 13'(esc_pkg::SECS_PER_HOUR));
        n_s6_rem2 = n_s6_hge ? (r_s5_hr - 13'(esc_pkg::SECS_PER_HOUR)) : r_s5_hr;

        // Subtract leap days since the epoch; year 2100 drops one
        n_s7_yr    = 12'(r_s6_q) + esc_pkg::EPOCH_YEAR_PREV;
        n_s7_leaps = n_s7_yr[11:2] - esc_pkg::LEAPS_AT_EPOCH
                   - 10'(r_s6_q >= esc_pkg::OFFSET_Y2100);
        n_s7_d0    = 10'(r_s6_yrem) - n_s7_leaps;
        n_s7_mprod = 21'(r_s6_rem2[11:2]) * 21'(esc_pkg::MIN_RECIP);

        // Negative day of year: step back one year
        n_s8_neg = r_s7_d0[9];
        n_s8_d   = n_s8_neg ? (r_s7_d0 + 10'(esc_pkg::DAYS_PER_YEAR) + 10'(r_s7_leap_prev))
                            : r_s7_d0;
        n_s8_mm  = 12'(r_s7_mest) * 12'(esc_pkg::SECS_PER_MIN);
        n_s8_mr  = r_s7_rem2 - n_s8_mm;

        // Month = number of month starts at or below the day of year
        n_s9_month = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_s8_d >= esc_pkg::f_month_start(4'(m), r_s8_leap)) begin
                n_s9_month = n_s9_month + 4'd1;
            end
        end
        n_s9_mge = (r_s8_mr >= 7'(esc_pkg::SECS_PER_MIN));
        n_s9_sec = n_s9_mge ? (r_s8_mr - 7'(esc_pkg::SECS_PER_MIN)) : r_s8_mr;

        n_s10_dom = r_s9_d - esc_pkg::f_month_start(r_s9_month, r_s9_leap) + 9'd1;
        n_s10_out.second           = r_s9_sec;
        n_s10_out.minute           = r_s9_min;
        n_s10_out.hour             = r_s9_hour;
        n_s10_out.day_of_month     = n_s10_dom[4:0];
        n_s10_out.month_index      = r_s9_month;
        n_s10_out.years_since_1900 = r_s9_year;
        n_s10_out.weekday          = r_s9_wday;
        n_s10_out.day_of_year      = r_s9_d + 9'd1;
    end

    // Payload registers: hold while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (n_adv[1]) begin
            r_s1_q  <= n_s1_prod[49:34];
            r_s1_x  <= s_axis_tdata[31:7];
            r_s1_lo <= s_axis_tdata[6:0];
        end
        if (n_adv[2]) begin
            r_s2_q  <= r_s1_q;
            r_s2_r  <= n_s2_diff[10:0];
            r_s2_lo <= r_s1_lo;
        end
        if (n_adv[3]) begin
            r_s3_days <= r_s2_q + 16'(n_s3_ge);
            r_s3_rem  <= {n_s3_r[9:0], r_s2_lo};
        end
        if (n_adv[4]) begin
            r_s4_days <= r_s3_days;
            r_s4_wx   <= n_s4_wx;
            r_s4_rem  <= r_s3_rem;
            r_s4_yest <= n_s4_yprod[31:24];
            r_s4_west <= n_s4_wprod[31:19];
            r_s4_hest <= n_s4_hprod[25:21];
        end
        if (n_adv[5]) begin
            r_s5_yest <= r_s4_yest;
            r_s5_yr   <= n_s5_yr[9:0];
            r_s5_wr   <= n_s5_wr[3:0];
            r_s5_hest <= r_s4_hest;
            r_s5_hr   <= n_s5_hr[12:0];
        end
        if (n_adv[6]) begin
            r_s6_q    <= r_s5_yest + 8'(n_s6_yge);
            r_s6_yrem <= n_s6_yrem[8:0];
            r_s6_wday <= n_s6_wday[2:0];
            r_s6_hour <= r_s5_hest + 5'(n_s6_hge);
            r_s6_rem2 <= n_s6_rem2[11:0];
        end
        if (n_adv[7]) begin
            r_s7_d0        <= n_s7_d0;
            r_s7_q         <= r_s6_q;
            r_s7_leap_cur  <= esc_pkg::f_is_leap(r_s6_q + esc_pkg::EPOCH_YEAR_1900);
            r_s7_leap_prev <= esc_pkg::f_is_leap(r_s6_q + esc_pkg::EPOCH_YEAR_1900 - 8'd1);
            r_s7_wday      <= r_s6_wday;
            r_s7_hour      <= r_s6_hour;
            r_s7_rem2      <= r_s6_rem2;
            r_s7_mest      <= n_s7_mprod[19:14];
        end
        if (n_adv[8]) begin
            r_s8_d    <= n_s8_d[8:0];
            r_s8_year <= r_s7_q + esc_pkg::EPOCH_YEAR_1900 - 8'(n_s8_neg);
            r_s8_leap <= n_s8_neg ? r_s7_leap_prev : r_s7_leap_cur;
            r_s8_wday <= r_s7_wday;
            r_s8_hour <= r_s7_hour;
            r_s8_mest <= r_s7_mest;
            r_s8_mr   <= n_s8_mr[6:0];
        end
        if (n_adv[9]) begin
            r_s9_d     <= r_s8_d;
            r_s9_year  <= r_s8_year;
            r_s9_leap  <= r_s8_leap;
            r_s9_wday  <= r_s8_wday;
            r_s9_hour  <= r_s8_hour;
            r_s9_month <= n_s9_month;
            r_s9_min   <= r_s8_mest + 6'(n_s9_mge);
            r_s9_sec   <= n_s9_sec[5:0];
        end
        if (n_adv[10]) begin
            r_s10_out <= n_s10_out;
        end
    end

    assign m_axis_tdata = {2'b00, r_s10_out};

`ifndef SYNTHESIS
    // Day of year after the year step-back never runs past a leap year end
    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] |-> (r_s8_d <= 9'd365))
        else $error("day of year out of range after year correction");

    // Month search lands inside the year
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_s10_out.month_index <= 4'd11))
        else $error("month index out of range");

    // Day of month is one-based
    a_dom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_s10_out.day_of_month != 5'd0))
        else $error("day of month is zero");

    // Input backpressure only when the output holds a result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with an empty output stage");
`endif

endmodule

// ----- tb/calendar_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_result_checker: scoreboard for the epoch-seconds converter
// Predicts the calendar fields of every accepted request and compares each
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module calendar_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,     // epoch_seconds[31:0]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,     // second minute hour mday month year wday yday pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    esc_pkg::t_cal expected_dates[$];
    esc_pkg::t_cal want_date;
    esc_pkg::t_cal got_date;
    int   fails   = 0;
    int   checked = 0;

    function automatic int unsigned leaps_through(input int unsigned year);
        return year / 4 - year / 100 + year / 400;
    endfunction

    function automatic bit leap_year(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int month_length(input int month, input int unsigned year);
        int len;
        case (month)
            1:           len = leap_year(year) ? 29 : 28;
            3, 5, 8, 10: len = 30;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Split into days and seconds of day, then walk year and months
    function automatic esc_pkg::t_cal calendar_of_seconds(input logic [31:0] secs);
        int unsigned   day_count;
        int unsigned   sec_of_day;
        int unsigned   year_num;
        int unsigned   hour_num;
        int            day_in_year;
        int            month;
        esc_pkg::t_cal cal;
        day_count  = secs / 32'd86400;
        sec_of_day = secs - day_count * 86400;
        year_num   = 1970 + day_count / 365;
        day_in_year = int'(day_count) - int'((year_num - 1970) * 365
                      + leaps_through(year_num - 1) - leaps_through(1969));
        // the estimate overshoots by one year near the end of a year
        if (day_in_year < 0) begin
            year_num    = year_num - 1;
            day_in_year = day_in_year + (leap_year(year_num) ? 366 : 365);
        end
        cal.day_of_year = 9'(day_in_year + 1);
        month = 0;
        while (month < 11 && day_in_year >= month_length(month, year_num)) begin
            day_in_year = day_in_year - month_length(month, year_num);
            month++;
        end
        hour_num             = sec_of_day / 3600;
        cal.hour             = 5'(hour_num);
        cal.minute           = 6'((sec_of_day - hour_num * 3600) / 60);
        cal.second           = 6'(sec_of_day % 60);
        cal.day_of_month     = 5'(day_in_year + 1);
        cal.month_index      = 4'(month);
        cal.years_since_1900 = 8'(year_num - 1900);
        cal.weekday          = 3'((day_count + 4) % 7);
        return cal;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_dates.size() == 0) begin
                    fails++;
                    $display("%0t ns: result with no request pending, expected none, actual %h",
                             $time, i_res_data);
                end else begin
                    want_date = expected_dates.pop_front();
                    got_date  = i_res_data[45:0];
                    check_field("second", want_date.second, got_date.second);
                    check_field("minute", want_date.minute, got_date.minute);
                    check_field("hour", want_date.hour, got_date.hour);
                    check_field("day_of_month", want_date.day_of_month, got_date.day_of_month);
                    check_field("month_index", want_date.month_index, got_date.month_index);
                    check_field("years_since_1900", want_date.years_since_1900,
                                got_date.years_since_1900);
                    check_field("weekday", want_date.weekday, got_date.weekday);
                    check_field("day_of_year", want_date.day_of_year, got_date.day_of_year);
                    checked++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_dates.push_back(calendar_of_seconds(i_req_data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_dates.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/epoch_seconds_to_calendar_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb: stimulus and verdict for the calendar converter
// Sends directed edge timestamps, then boundary-heavy random ones under three
// idle/stall mixes, while the checker scores every result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;

    localparam int RANDOM_PER_PHASE = 500;
    localparam int LONG_HOLD_CYCLES = 60;

    // Drive every block input to a known level from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;        // epoch_seconds[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;              // second minute hour mday month year wday yday pad

    int fail_count;
    int pending_results;
    int checked_results;

    // Idle mix shared by the sender and receiver processes
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;     // set to a cycle count to stall the output that long
    int sent_count     = 0;

    epoch_seconds_to_calendar dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    calendar_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (checked_results)
    );

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    // Bound the run well past the slowest legal pass
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, or a long hold when one is requested
    initial begin : receiver
        int hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request and hold it until the handshake; idle first at random
    task automatic send_request(input logic [31:0] secs);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sent_count++;
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic longint year_start_secs(input int year);
        int prev;
        prev = year - 1;
        return longint'((year - 1970) * 365 + (prev / 4 - prev / 100 + prev / 400)
                        - (1969 / 4 - 1969 / 100 + 1969 / 400)) * 86400;
    endfunction

    // Favor year, month and day edges; keep a share of uniform values
    function automatic logic [31:0] random_seconds();
        int     pick;
        longint candidate;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 70) begin
            candidate = year_start_secs($urandom_range(1971, 2106))
                        + longint'($urandom_range(0, 7200)) - 3600;
        end else if (pick < 85) begin
            candidate = year_start_secs($urandom_range(1970, 2105))
                        + longint'($urandom_range(0, 365)) * 86400
                        + longint'($urandom_range(0, 2)) - 1;
        end else begin
            candidate = longint'($urandom_range(0, 49710)) * 86400
                        + longint'($urandom_range(0, 2)) - 1;
        end
        if (candidate < 0 || candidate > 64'hFFFF_FFFF) begin
            return $urandom;
        end
        return candidate[31:0];
    endfunction

    initial begin
        logic [31:0] edge_cases[$];

        // Hold reset low from time zero, then release it once for good
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, leap days, century rule, last representable second
        edge_cases = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                       32'd86400, 32'd68169600, 32'd94521600, 32'd94607999,
                       32'd946684799, 32'd946684800, 32'd951782400, 32'd978307199,
                       32'd4102444799, 32'd4102444800, 32'd4107542399, 32'd4107542400,
                       32'd4291891200, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        foreach (edge_cases[i]) begin
            send_request(edge_cases[i]);
        end
        wait_drained();

        // Phase one: sender idles lightly, receiver stalls often
        send_idle_pct  = 15;
        recv_stall_pct = 53;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_seconds());
            // pause the sender once mid-phase until the pipeline empties
            if (n == RANDOM_PER_PHASE / 2) begin
                wait_drained();
            end
        end
        wait_drained();

        // Phase two: roles swapped
        send_idle_pct  = 53;
        recv_stall_pct = 15;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_seconds());
        end

        // Phase three: full rate, with one long output hold to back up the pipeline
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == 100) begin
                hold_request = LONG_HOLD_CYCLES;
            end
            send_request(random_seconds());
        end
        wait_drained();

        // Let any stray result surface before the verdict
        repeat (esc_pkg::STAGES + 10) @(posedge i_clk);

        $display("Sent %0d timestamps, %0d results checked: edge values, year/month/day",
                 sent_count, checked_results);
        $display("boundaries and uniform 32-bit values under mixed idle, stall and hold traffic.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/esc_pkg.sv
rtl/epoch_seconds_to_calendar.sv
tb/calendar_result_checker.sv
tb/epoch_seconds_to_calendar_tb.sv
